// ===== hdl/bqd_pkg.sv =====
// Shared constants, types and helpers of the Bayer quad downscaler.
package bqd_pkg;

  // Sample and geometry sizes.
  localparam int PixW     = 16;
  localparam int MaxWidth = 4096;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int HalfW    = ColW - 1;
  localparam int BankDepth = MaxWidth / 2;

  // Configuration port.
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 13;

  // Queue between the front and back parts.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QLvlW  = $clog2(QDepth + 1);

  // Register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 1'd0,
    CfgBayerPattern = 1'd1
  } cfg_reg_e;

  // Colour filter layouts.
  typedef enum logic [1:0] {
    PatRggb = 2'd0,
    PatBggr = 2'd1,
    PatGrbg = 2'd2,
    PatGbrg = 2'd3
  } bayer_pattern_e;

  // One complete quad waiting for colour selection.
  typedef struct packed {
    logic [PixW-1:0] ul;
    logic [PixW-1:0] ur;
    logic [PixW-1:0] ll;
    logic [PixW-1:0] lr;
    bayer_pattern_e  pattern;
  } job_t;

  // Reset value of the last column index (full width row).
  localparam logic [ColW-1:0] LastColRst = ColW'(MaxWidth - 1);

  // Last column index of a row for a written width, once the width is rounded down to even
  // and held to at least two and at most the line store size.
  function automatic logic [ColW-1:0] last_col(input logic [CfgDataW-1:0] width);
    logic [CfgDataW:0] w;
    w = {1'b0, width[CfgDataW-1:1], 1'b0};
    if (w < (CfgDataW+1)'(2)) begin
      w = (CfgDataW+1)'(2);
    end
    if (w > (CfgDataW+1)'(MaxWidth)) begin
      w = (CfgDataW+1)'(MaxWidth);
    end
    return ColW'(w - (CfgDataW+1)'(1));
  endfunction

endpackage

// ===== hdl/bqd_ram.sv =====
// Simple dual-port RAM with a registered read port.
module bqd_ram #(
  parameter int Depth = 2048,
  parameter int Width = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bqd_front.sv =====
// Front part: configuration, raster tracking, line store and quad assembly.
module bqd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bqd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bqd_pkg::CfgDataW-1:0]  cfg_data_i,
  // Pixel input.
  input  logic                          pix_valid_i,
  output logic                          pix_ready_o,
  input  logic [bqd_pkg::PixW-1:0]      pix_i,
  // Quad output towards the queue.
  input  logic [bqd_pkg::QLvlW-1:0]     q_level_i,
  output logic                          push_o,
  output bqd_pkg::job_t                 job_o
);

  logic [bqd_pkg::ColW-1:0] last_col_q;
  bqd_pkg::bayer_pattern_e  pattern_q;
  logic [bqd_pkg::ColW-1:0] col_q, col_d;
  logic                     odd_row_q, odd_row_d;
  logic [bqd_pkg::PixW-1:0] left_q;
  logic                     s1_valid_q;
  logic [bqd_pkg::PixW-1:0] s1_ll_q, s1_lr_q;
  bqd_pkg::bayer_pattern_e  s1_pattern_q;
  logic                     accept;
  logic                     quad_done;
  logic                     we_even, we_odd;
  logic [bqd_pkg::PixW-1:0] ul_rdata, ur_rdata;
  logic [bqd_pkg::QLvlW:0]  committed;

  // Configuration registers; the width is kept as the last column index.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= bqd_pkg::LastColRst;
      pattern_q  <= bqd_pkg::PatRggb;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == bqd_pkg::CfgImageWidth) begin
        last_col_q <= bqd_pkg::last_col(cfg_data_i);
      end
      if (cfg_index_i == bqd_pkg::CfgBayerPattern) begin
        pattern_q <= bqd_pkg::bayer_pattern_e'(cfg_data_i[1:0]);
      end
    end
  end

  // Accept while the queue can still take every quad already in flight.
  assign committed   = {1'b0, q_level_i} + {{bqd_pkg::QLvlW{1'b0}}, s1_valid_q};
  assign pix_ready_o = committed < (bqd_pkg::QLvlW+1)'(bqd_pkg::QDepth);
  assign accept      = pix_valid_i & pix_ready_o;
  assign quad_done   = accept & odd_row_q & col_q[0];

  // Column and row tracking; the row ends once the column reaches the last column index.
  always_comb begin
    col_d     = col_q;
    odd_row_d = odd_row_q;
    if (accept) begin
      if (col_q >= last_col_q) begin
        col_d     = '0;
        odd_row_d = ~odd_row_q;
      end else begin
        col_d = col_q + bqd_pkg::ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      odd_row_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      odd_row_q <= odd_row_d;
    end
  end

  // The left pixel of a quad is the even-column sample of an odd row.
  always_ff @(posedge clk_i) begin
    if (accept & odd_row_q & ~col_q[0]) begin
      left_q <= pix_i;
    end
  end

  // Line store split into even and odd column banks, one word each per pair.
  assign we_even = accept & ~odd_row_q & ~col_q[0];
  assign we_odd  = accept & ~odd_row_q & col_q[0];

  bqd_ram #(
    .Depth (bqd_pkg::BankDepth),
    .Width (bqd_pkg::PixW)
  ) u_bank_even (
    .clk_i   (clk_i),
    .we_i    (we_even),
    .waddr_i (col_q[bqd_pkg::ColW-1:1]),
    .wdata_i (pix_i),
    .re_i    (quad_done),
    .raddr_i (col_q[bqd_pkg::ColW-1:1]),
    .rdata_o (ul_rdata)
  );

  bqd_ram #(
    .Depth (bqd_pkg::BankDepth),
    .Width (bqd_pkg::PixW)
  ) u_bank_odd (
    .clk_i   (clk_i),
    .we_i    (we_odd),
    .waddr_i (col_q[bqd_pkg::ColW-1:1]),
    .wdata_i (pix_i),
    .re_i    (quad_done),
    .raddr_i (col_q[bqd_pkg::ColW-1:1]),
    .rdata_o (ur_rdata)
  );

  // Lower row samples are registered alongside the store read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= quad_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (quad_done) begin
      s1_ll_q      <= left_q;
      s1_lr_q      <= pix_i;
      s1_pattern_q <= pattern_q;
    end
  end

  // Completed quad into the queue.
  assign push_o        = s1_valid_q;
  assign job_o.ul      = ul_rdata;
  assign job_o.ur      = ur_rdata;
  assign job_o.ll      = s1_ll_q;
  assign job_o.lr      = s1_lr_q;
  assign job_o.pattern = s1_pattern_q;

endmodule

// ===== hdl/bqd_queue.sv =====
// Short first-in first-out queue of quads between the front and back parts.
module bqd_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  bqd_pkg::job_t             job_i,
  input  logic                      pop_i,
  output logic                      head_valid_o,
  output bqd_pkg::job_t             head_o,
  output logic [bqd_pkg::QLvlW-1:0] level_o
);

  bqd_pkg::job_t              entries_q [bqd_pkg::QDepth];
  logic [bqd_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [bqd_pkg::QLvlW-1:0]  level_q;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + bqd_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + bqd_pkg::QPtrW'(1);
      end
      if (push_i & ~pop_i) begin
        level_q <= level_q + bqd_pkg::QLvlW'(1);
      end else if (~push_i & pop_i) begin
        level_q <= level_q - bqd_pkg::QLvlW'(1);
      end
    end
  end

  assign head_valid_o = level_q != '0;
  assign head_o       = entries_q[rd_ptr_q];
  assign level_o      = level_q;

endmodule

// ===== hdl/bqd_back.sv =====
// Back part: colour site selection and the output register.
module bqd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        head_valid_i,
  input  bqd_pkg::job_t               head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [3*bqd_pkg::PixW-1:0]  out_data_o
);

  logic                     out_valid_q;
  logic [3*bqd_pkg::PixW-1:0] out_data_q;
  logic [bqd_pkg::PixW-1:0] red, green, blue;

  // Pick the red, green and blue sites for the layout.
  always_comb begin
    case (head_i.pattern)
      bqd_pkg::PatRggb: begin
        red = head_i.ul; green = head_i.ll; blue = head_i.lr;
      end
      bqd_pkg::PatBggr: begin
        red = head_i.lr; green = head_i.ll; blue = head_i.ul;
      end
      bqd_pkg::PatGrbg: begin
        red = head_i.ur; green = head_i.lr; blue = head_i.ll;
      end
      bqd_pkg::PatGbrg: begin
        red = head_i.ll; green = head_i.lr; blue = head_i.ur;
      end
      default: begin
        red = head_i.ul; green = head_i.ll; blue = head_i.lr;
      end
    endcase
  end

  // Load the output register whenever it is empty or being emptied.
  assign pop_o = head_valid_i & (~out_valid_q | out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q <= {blue, green, red};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hdl/bayer_quad_downscaler.sv =====
// Top level of the Bayer quad downscaler: half-resolution RGB from raw Bayer.
// Throughput: one pixel word per cycle; the input stalls only when the quad queue backs up.
// After the edge that accepts its last pixel, an RGB word passes through the line store read,
// the queue entry and then the output register before it is valid.
// Reset clears the raster position, queue and output valid; the width returns to
// 4096 and the layout to RGGB. The line store is not cleared.
module bayer_quad_downscaler (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bqd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [bqd_pkg::CfgDataW-1:0]       cfg_data_i,
  // Raw pixel stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [bqd_pkg::PixW-1:0]           s_axis_tdata,  // [15:0] pixel
  // RGB stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [3*bqd_pkg::PixW-1:0]         m_axis_tdata   // [15:0] red, [31:16] green,
                                                            // [47:32] blue
);

  logic                      push;
  bqd_pkg::job_t             job;
  logic                      pop;
  logic                      head_valid;
  bqd_pkg::job_t             head;
  logic [bqd_pkg::QLvlW-1:0] q_level;

  // Front part.
  bqd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_valid_i (s_axis_tvalid),
    .pix_ready_o (s_axis_tready),
    .pix_i       (s_axis_tdata),
    .q_level_i   (q_level),
    .push_o      (push),
    .job_o       (job)
  );

  // Queue between the parts.
  bqd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (job),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .level_o      (q_level)
  );

  // Back part.
  bqd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // The queue never holds more than its depth.
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= bqd_pkg::QLvlW'(bqd_pkg::QDepth))
    else $error("queue level above depth");

  // A quad is never pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (q_level < bqd_pkg::QLvlW'(bqd_pkg::QDepth)) || pop)
    else $error("push into full queue");

  // An RGB word only appears after a quad was taken from the queue.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(pop))
    else $error("output word without a queued quad");
`endif

endmodule
